@@ rtl/obgp_pkg.sv @@
// obgp_pkg: shared constants, types and microcode ROM for the oriented box grower.
// No dependencies; used by every other file of the block but obgp_checker.
package obgp_pkg;

  // Default widths of the block
  localparam int COORD_BITS_DEF = 20;
  localparam int BASIS_BITS_DEF = 16;

  // Configuration port
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AXIS_I       = 3'd0,
    REG_AXIS_J       = 3'd1,
    REG_AXIS_K       = 3'd2,
    REG_START_CENTER = 3'd3,
    REG_START_HALF   = 3'd4
  } cfg_reg_e;

  // Reset values of the basis registers, truncated to the packed width
  localparam logic [63:0] AXIS_I_RST = 64'd16384;
  localparam logic [63:0] AXIS_J_RST = 64'd268435456;
  localparam logic [63:0] AXIS_K_RST = 64'd1099511627776;

  // Microcode
  localparam int STEP_W = 4;
  typedef logic [STEP_W-1:0] step_t;
  typedef logic [1:0]        axis_idx_t;

  typedef enum logic [1:0] {
    MUL_NONE,
    MUL_PROJ,
    MUL_MOVE
  } mul_op_e;

  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_WAIT_IN,
    JMP_WAIT_OUT
  } jump_e;

  typedef struct packed {
    mul_op_e   mul_op;
    axis_idx_t mul_axis;
    logic      sum_en;
    axis_idx_t sum_axis;
    logic      grow_en;
    axis_idx_t grow_axis;
    logic      apply_en;
    axis_idx_t apply_axis;
    jump_e     jump;
    step_t     target;
  } ucw_t;

  // Sequencer to datapath
  typedef struct packed {
    ucw_t cw;
    logic accept;
    logic emit;
  } seq_ctrl_t;

  localparam step_t STEP_IDLE = 4'd0;

  // Program: projections on three lanes, then grow / move / apply per axis.
  function automatic ucw_t ucode(input step_t step);
    ucw_t cw;
    cw            = '0;
    cw.mul_op     = MUL_NONE;
    cw.jump       = JMP_NEXT;
    cw.target     = STEP_IDLE;
    unique case (step)
      4'd0: cw.jump = JMP_WAIT_IN;
      4'd1: begin
        cw.mul_op = MUL_PROJ; cw.mul_axis = 2'd0;
      end
      4'd2: begin
        cw.mul_op = MUL_PROJ; cw.mul_axis = 2'd1;
        cw.sum_en = 1'b1;     cw.sum_axis = 2'd0;
      end
      4'd3: begin
        cw.mul_op = MUL_PROJ; cw.mul_axis = 2'd2;
        cw.sum_en = 1'b1;     cw.sum_axis = 2'd1;
      end
      4'd4: begin
        cw.sum_en  = 1'b1; cw.sum_axis  = 2'd2;
        cw.grow_en = 1'b1; cw.grow_axis = 2'd0;
      end
      4'd5: begin
        cw.mul_op  = MUL_MOVE; cw.mul_axis  = 2'd0;
        cw.grow_en = 1'b1;     cw.grow_axis = 2'd1;
      end
      4'd6: begin
        cw.apply_en = 1'b1;     cw.apply_axis = 2'd0;
        cw.mul_op   = MUL_MOVE; cw.mul_axis   = 2'd1;
        cw.grow_en  = 1'b1;     cw.grow_axis  = 2'd2;
      end
      4'd7: begin
        cw.apply_en = 1'b1;     cw.apply_axis = 2'd1;
        cw.mul_op   = MUL_MOVE; cw.mul_axis   = 2'd2;
      end
      4'd8: begin
        cw.apply_en = 1'b1; cw.apply_axis = 2'd2;
      end
      4'd9: begin
        cw.jump   = JMP_WAIT_OUT;
        cw.target = STEP_IDLE;
      end
      default: begin
        cw.jump   = JMP_WAIT_OUT;
        cw.target = STEP_IDLE;
      end
    endcase
    return cw;
  endfunction

endpackage

@@ rtl/obgp_ifs.sv @@
// obgp_ifs: valid/ready channel interfaces of the oriented box grower.
// Depends on obgp_pkg for the configuration index width.
interface obgp_point_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] point_x;
  logic signed [COORD_BITS-1:0] point_y;
  logic signed [COORD_BITS-1:0] point_z;
  logic                         restart;

  modport source (output valid, point_x, point_y, point_z, restart, input ready);
  modport sink   (input valid, point_x, point_y, point_z, restart, output ready);
endinterface

interface obgp_box_if #(
  parameter int COORD_BITS = 20
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] center_x;
  logic signed [COORD_BITS-1:0] center_y;
  logic signed [COORD_BITS-1:0] center_z;
  logic        [COORD_BITS-2:0] half_i;
  logic        [COORD_BITS-2:0] half_j;
  logic        [COORD_BITS-2:0] half_k;

  modport source (output valid, center_x, center_y, center_z, half_i, half_j, half_k,
                  input ready);
  modport sink   (input valid, center_x, center_y, center_z, half_i, half_j, half_k,
                  output ready);
endinterface

interface obgp_cfg_if #(
  parameter int DATA_W = 60
);
  logic                           valid;
  logic                           ready;
  logic [obgp_pkg::CFG_IDX_W-1:0] index;
  logic [DATA_W-1:0]              data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/obgp_useq.sv @@
// obgp_useq: microcode sequencer - step counter, control ROM and conditional jumps.
// Depends on obgp_pkg (control word type and ROM function).
module obgp_useq (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                out_free_i,
  output logic                in_ready_o,
  output obgp_pkg::seq_ctrl_t ctrl_o
);
  import obgp_pkg::*;

  step_t step_q, step_d;
  ucw_t  cw;

  assign cw = ucode(step_q);

  always_comb begin
    step_d        = step_q + step_t'(1);
    ctrl_o.cw     = cw;
    ctrl_o.accept = 1'b0;
    ctrl_o.emit   = 1'b0;
    unique case (cw.jump)
      JMP_WAIT_IN: begin
        ctrl_o.accept = in_valid_i;
        if (!in_valid_i) step_d = step_q;
      end
      JMP_WAIT_OUT: begin
        ctrl_o.emit = out_free_i;
        step_d      = out_free_i ? cw.target : step_q;
      end
      default: ;
    endcase
  end

  assign in_ready_o = (cw.jump == JMP_WAIT_IN);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

@@ rtl/oriented_box_grow_to_point.sv @@
// Oriented box grower: one point item in, one updated box item out.
// A new point is taken only after the last one's result is in the result register, which
// frees the input side while that result waits. The microcode program runs accept and emit
// steps around three projection and three move passes over three shared lane multipliers.
// Reset is asynchronous active low: box zero, basis and start registers to their reset
// values, sequencer idle, no result pending.
module oriented_box_grow_to_point #(
  parameter int COORD_BITS = obgp_pkg::COORD_BITS_DEF,
  parameter int BASIS_BITS = obgp_pkg::BASIS_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  obgp_point_if.sink  point_i,
  obgp_box_if.source  box_o,
  obgp_cfg_if.sink    cfg_i
);
  import obgp_pkg::*;

  // Widths. Basis components are Q1.(BASIS_BITS-2).
  localparam int FRAC    = BASIS_BITS - 2;
  localparam int AXIS_W  = 3 * BASIS_BITS;
  localparam int PACK_W  = 3 * COORD_BITS;
  localparam int HALF_W  = COORD_BITS - 1;
  localparam int MUL_A_W = COORD_BITS + 5;   // offset or signed growth
  localparam int PROD_W  = MUL_A_W + BASIS_BITS;
  localparam int SUM_W   = PROD_W + 2;
  localparam int PROJ_W  = MUL_A_W;
  localparam int MOVE_W  = PROD_W - FRAC;
  localparam int CACC_W  = MOVE_W + 1;

  localparam logic signed [SUM_W-1:0]  SUM_RND  = SUM_W'(1) << (FRAC - 1);
  localparam logic signed [PROD_W-1:0] PROD_RND = PROD_W'(1) << (FRAC - 1);
  localparam logic [PROJ_W-1:0]        HALF_MAX_P = PROJ_W'({HALF_W{1'b1}});
  localparam logic signed [CACC_W-1:0] C_MAX = CACC_W'({1'b0, {(COORD_BITS-1){1'b1}}});
  localparam logic signed [CACC_W-1:0] C_MIN = -C_MAX - CACC_W'(1);

  // ---------------------------------------------------------------------------------
  // Configuration registers; writes are always taken, unknown indexes ignored.
  // ---------------------------------------------------------------------------------
  logic [AXIS_W-1:0] axis_q [3];
  logic [PACK_W-1:0] start_center_q;
  logic [PACK_W-1:0] start_half_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q[0]      <= AXIS_W'(AXIS_I_RST);
      axis_q[1]      <= AXIS_W'(AXIS_J_RST);
      axis_q[2]      <= AXIS_W'(AXIS_K_RST);
      start_center_q <= '0;
      start_half_q   <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        REG_AXIS_I:       axis_q[0]      <= cfg_i.data[AXIS_W-1:0];
        REG_AXIS_J:       axis_q[1]      <= cfg_i.data[AXIS_W-1:0];
        REG_AXIS_K:       axis_q[2]      <= cfg_i.data[AXIS_W-1:0];
        REG_START_CENTER: start_center_q <= cfg_i.data[PACK_W-1:0];
        REG_START_HALF:   start_half_q   <= cfg_i.data[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  // Unpacked basis components: ax_comp[axis][x/y/z]
  logic signed [BASIS_BITS-1:0] ax_comp [3][3];
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      for (int n = 0; n < 3; n++) begin
        ax_comp[a][n] = axis_q[a][n*BASIS_BITS +: BASIS_BITS];
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------------
  seq_ctrl_t ctrl;
  logic      out_valid_q;
  logic      out_free;

  assign out_free = !out_valid_q || box_o.ready;

  obgp_useq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .out_free_i (out_free),
    .in_ready_o (point_i.ready),
    .ctrl_o     (ctrl)
  );

  // ---------------------------------------------------------------------------------
  // Datapath state
  // ---------------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] center_q [3];
  logic        [HALF_W-1:0]     half_q   [3];
  logic signed [COORD_BITS-1:0] point_q  [3];
  logic signed [PROJ_W-1:0]     proj_q   [3];
  logic signed [MUL_A_W-1:0]    shg_q    [3];  // growth with the projection's sign applied
  logic                         grow_q   [3];
  logic signed [PROD_W-1:0]     prod_q   [3];

  logic signed [COORD_BITS-1:0] in_pt [3];
  assign in_pt[0] = point_i.point_x;
  assign in_pt[1] = point_i.point_y;
  assign in_pt[2] = point_i.point_z;

  // Three lane multipliers: offset * component for projections, growth * component
  // for centre moves.
  logic signed [PROD_W-1:0]     prod_d [3];
  logic signed [MUL_A_W-1:0]    mul_a  [3];
  logic signed [BASIS_BITS-1:0] mul_b  [3];
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      mul_b[n] = ax_comp[ctrl.cw.mul_axis][n];
      if (ctrl.cw.mul_op == MUL_PROJ) begin
        mul_a[n] = MUL_A_W'(point_q[n]) - MUL_A_W'(center_q[n]);
      end else begin
        mul_a[n] = shg_q[ctrl.cw.mul_axis];
      end
      prod_d[n] = mul_a[n] * mul_b[n];
    end
  end

  // Projection: sum the three lane products and round, ties towards +inf.
  logic signed [SUM_W-1:0]  sum_rnd;
  logic signed [PROJ_W-1:0] proj_d;
  assign sum_rnd = SUM_W'(prod_q[0]) + SUM_W'(prod_q[1]) + SUM_W'(prod_q[2]) + SUM_RND;
  assign proj_d  = sum_rnd[FRAC +: PROJ_W];

  // Growth on one axis: half the excess of |proj| over the half extent.
  logic signed [PROJ_W-1:0] grow_proj;
  logic                     grow_neg;
  logic [PROJ_W-1:0]        grow_mag;
  logic [PROJ_W-1:0]        grow_half;
  logic [PROJ_W-1:0]        grow_hg;
  logic [PROJ_W-1:0]        grow_nh;
  logic                     grow_hit;
  logic [HALF_W-1:0]        grow_nh_sat;
  logic signed [MUL_A_W-1:0] grow_shg;
  always_comb begin
    grow_proj   = proj_q[ctrl.cw.grow_axis];
    grow_neg    = grow_proj[PROJ_W-1];
    grow_mag    = grow_neg ? (~grow_proj + PROJ_W'(1)) : grow_proj;
    grow_half   = PROJ_W'(half_q[ctrl.cw.grow_axis]);
    grow_hit    = grow_half < grow_mag;
    grow_hg     = (grow_mag - grow_half) >> 1;
    grow_nh     = grow_half + grow_hg;
    grow_nh_sat = (grow_nh > HALF_MAX_P) ? {HALF_W{1'b1}} : grow_nh[HALF_W-1:0];
    grow_shg    = grow_neg ? -signed'(grow_hg) : signed'(grow_hg);
  end

  // Centre move per lane, rounded then saturated.
  logic signed [COORD_BITS-1:0] center_mv [3];
  logic signed [PROD_W-1:0]     mv_rnd    [3];
  logic signed [CACC_W-1:0]     mv_sum    [3];
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      mv_rnd[n] = prod_q[n] + PROD_RND;
      mv_sum[n] = CACC_W'(center_q[n]) + CACC_W'(signed'(mv_rnd[n][PROD_W-1:FRAC]));
      if (mv_sum[n] > C_MAX) begin
        center_mv[n] = C_MAX[COORD_BITS-1:0];
      end else if (mv_sum[n] < C_MIN) begin
        center_mv[n] = C_MIN[COORD_BITS-1:0];
      end else begin
        center_mv[n] = mv_sum[n][COORD_BITS-1:0];
      end
    end
  end

  // Box state: reset to zero, reloaded from the start registers on restart.
  logic [COORD_BITS-1:0] start_h [3];
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      start_h[n] = start_half_q[n*COORD_BITS +: COORD_BITS];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int n = 0; n < 3; n++) begin
        center_q[n] <= '0;
        half_q[n]   <= '0;
      end
    end else if (ctrl.accept && point_i.restart) begin
      for (int n = 0; n < 3; n++) begin
        center_q[n] <= start_center_q[n*COORD_BITS +: COORD_BITS];
        half_q[n]   <= start_h[n][COORD_BITS-1] ? {HALF_W{1'b1}} : start_h[n][HALF_W-1:0];
      end
    end else begin
      if (ctrl.cw.grow_en && grow_hit) begin
        half_q[ctrl.cw.grow_axis] <= grow_nh_sat;
      end
      if (ctrl.cw.apply_en && grow_q[ctrl.cw.apply_axis]) begin
        for (int n = 0; n < 3; n++) begin
          center_q[n] <= center_mv[n];
        end
      end
    end
  end

  // Working registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (ctrl.accept) begin
      for (int n = 0; n < 3; n++) point_q[n] <= in_pt[n];
    end
    if (ctrl.cw.mul_op != MUL_NONE) begin
      for (int n = 0; n < 3; n++) prod_q[n] <= prod_d[n];
    end
    if (ctrl.cw.sum_en) begin
      proj_q[ctrl.cw.sum_axis] <= proj_d;
    end
    if (ctrl.cw.grow_en) begin
      shg_q[ctrl.cw.grow_axis]  <= grow_shg;
      grow_q[ctrl.cw.grow_axis] <= grow_hit;
    end
  end

  // ---------------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] out_center_q [3];
  logic        [HALF_W-1:0]     out_half_q   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (box_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.emit) begin
      for (int n = 0; n < 3; n++) begin
        out_center_q[n] <= center_q[n];
        out_half_q[n]   <= half_q[n];
      end
    end
  end

  assign box_o.valid    = out_valid_q;
  assign box_o.center_x = out_center_q[0];
  assign box_o.center_y = out_center_q[1];
  assign box_o.center_z = out_center_q[2];
  assign box_o.half_i   = out_half_q[0];
  assign box_o.half_j   = out_half_q[1];
  assign box_o.half_k   = out_half_q[2];

endmodule

@@ rtl/obgp_checker.sv @@
// obgp_checker: port-level assertions for the oriented box grower, and its bind.
// Depends on the top level oriented_box_grow_to_point.
module obgp_checker #(
  parameter int OUT_W = 117
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [OUT_W-1:0] out_data_i
);
  logic [1:0] pend_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  // items accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_ready_i)
    else $error("input ready straight after an accepted item");

  a_no_invented_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (pend_q != 2'd0))
    else $error("result shown with no item outstanding");

  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q != 2'd3)
    else $error("more than two items outstanding");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result dropped or changed");

endmodule

bind oriented_box_grow_to_point obgp_checker #(
  .OUT_W (3 * COORD_BITS + 3 * (COORD_BITS - 1))
) u_obgp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (point_i.valid),
  .in_ready_i  (point_i.ready),
  .out_valid_i (box_o.valid),
  .out_ready_i (box_o.ready),
  .out_data_i  ({box_o.center_x, box_o.center_y, box_o.center_z,
                 box_o.half_i, box_o.half_j, box_o.half_k})
);

@@ tb/sv/oriented_box_grow_to_point_test.sv @@
// Self-checking testbench of the oriented box grower: random and directed points and
// register settings, every box item checked against an in-bench predictor.
// Depends on obgp_pkg, the obgp_*_if interfaces and the oriented_box_grow_to_point RTL.
module oriented_box_grow_to_point_test;
  timeunit 1ns;
  timeprecision 1ps;

  import obgp_pkg::*;

  localparam int     CW        = COORD_BITS_DEF;
  localparam int     BW        = BASIS_BITS_DEF;
  localparam int     FRAC      = BW - 2;
  localparam int     DW        = 60;
  localparam int     AW        = 3 * BW;
  localparam longint COORD_MAX = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COORD_MIN = -COORD_MAX - 1;

  // indices past the last register: the block must drop these writes
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_A = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_C = 3'd7;
  localparam logic [CFG_IDX_W-1:0] AXIS_REG [3] = '{REG_AXIS_I, REG_AXIS_J, REG_AXIS_K};

  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 12;    // quiet time before a register write
  localparam int TAIL_CYCLES    = 30;
  localparam int WATCHDOG_LIMIT = 2000;  // cycles without any handshake
  localparam int RAND_ITEMS     = 1100;
  localparam int CALM_ITEMS     = 100;   // closing stretch, no idling either side

  typedef enum logic [1:0] {OP_POINT, OP_CFG, OP_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e           kind;
    logic [CW-1:0]        x, y, z;
    logic                 restart;
    logic [CFG_IDX_W-1:0] idx;
    logic [DW-1:0]        data;
    bit                   bursty;
  } stim_op_t;

  typedef struct {
    logic signed [CW-1:0] center_x, center_y, center_z;
    logic        [CW-2:0] half_i, half_j, half_k;
  } box_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  obgp_point_if #(.COORD_BITS(CW)) point_if ();
  obgp_box_if   #(.COORD_BITS(CW)) box_if   ();
  obgp_cfg_if   #(.DATA_W(DW))     cfg_if   ();

  // driven copies of the block's inputs, known from time zero
  logic                 pt_valid   = 1'b0;
  logic [CW-1:0]        pt_x       = '0;
  logic [CW-1:0]        pt_y       = '0;
  logic [CW-1:0]        pt_z       = '0;
  logic                 pt_restart = 1'b0;
  logic                 cf_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cf_idx     = '0;
  logic [DW-1:0]        cf_data    = '0;
  logic                 res_ready  = 1'b0;

  assign point_if.valid   = pt_valid;
  assign point_if.point_x = pt_x;
  assign point_if.point_y = pt_y;
  assign point_if.point_z = pt_z;
  assign point_if.restart = pt_restart;
  assign cfg_if.valid     = cf_valid;
  assign cfg_if.index     = cf_idx;
  assign cfg_if.data      = cf_data;
  assign box_if.ready     = res_ready;

  oriented_box_grow_to_point #(
    .COORD_BITS(CW),
    .BASIS_BITS(BW)
  ) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .point_i(point_if),
    .box_o  (box_if),
    .cfg_i  (cfg_if)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of the registers and of the box
  // ---------------------------------------------------------------------------
  logic [AW-1:0] basis_reg [3] = '{AXIS_I_RST[AW-1:0], AXIS_J_RST[AW-1:0], AXIS_K_RST[AW-1:0]};
  logic [DW-1:0] start_ctr_reg  = '0;
  logic [DW-1:0] start_half_reg = '0;
  longint        box_ctr  [3]   = '{0, 0, 0};
  longint        box_half [3]   = '{0, 0, 0};

  function automatic void store_reg_write(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    case (idx)
      REG_AXIS_I:       basis_reg[0]   = data[AW-1:0];
      REG_AXIS_J:       basis_reg[1]   = data[AW-1:0];
      REG_AXIS_K:       basis_reg[2]   = data[AW-1:0];
      REG_START_CENTER: start_ctr_reg  = data;
      REG_START_HALF:   start_half_reg = data;
      default: ;
    endcase
  endfunction

  // round to nearest, ties upwards; >>> on a signed longint floors
  function automatic longint round_frac(longint v);
    return (v + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic box_t grow_box_to_point(logic signed [CW-1:0] px, py, pz, logic restart);
    longint comp [3][3];
    longint pos  [3];
    longint proj [3];
    longint acc, mag, grow, hv, prod;
    box_t   res;
    if (restart) begin
      for (int n = 0; n < 3; n++) begin
        box_ctr[n]  = longint'($signed(start_ctr_reg[CW*n +: CW]));
        hv          = longint'(start_half_reg[CW*n +: CW]);
        box_half[n] = (hv > COORD_MAX) ? COORD_MAX : hv;
      end
    end
    for (int a = 0; a < 3; a++)
      for (int n = 0; n < 3; n++)
        comp[a][n] = longint'($signed(basis_reg[a][BW*n +: BW]));
    pos[0] = longint'(px);
    pos[1] = longint'(py);
    pos[2] = longint'(pz);
    // all three projections from the centre as it stood before this point
    for (int a = 0; a < 3; a++) begin
      acc = 0;
      for (int n = 0; n < 3; n++)
        acc += (pos[n] - box_ctr[n]) * comp[a][n];
      proj[a] = round_frac(acc);
    end
    for (int a = 0; a < 3; a++) begin
      mag = (proj[a] < 0) ? -proj[a] : proj[a];
      if (box_half[a] < mag) begin
        grow        = (mag - box_half[a]) >>> 1;
        hv          = box_half[a] + grow;
        box_half[a] = (hv > COORD_MAX) ? COORD_MAX : hv;
        for (int n = 0; n < 3; n++) begin
          prod = comp[a][n] * grow;
          if (proj[a] < 0) prod = -prod;
          hv = box_ctr[n] + round_frac(prod);
          box_ctr[n] = (hv > COORD_MAX) ? COORD_MAX : ((hv < COORD_MIN) ? COORD_MIN : hv);
        end
      end
    end
    res.center_x = box_ctr[0][CW-1:0];
    res.center_y = box_ctr[1][CW-1:0];
    res.center_z = box_ctr[2][CW-1:0];
    res.half_i   = box_half[0][CW-2:0];
    res.half_j   = box_half[1][CW-2:0];
    res.half_k   = box_half[2][CW-2:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus queue and its builders
  // ---------------------------------------------------------------------------
  stim_op_t stim_q [$];
  box_t     box_expect_q [$];

  function automatic void push_point(logic [CW-1:0] x, y, z, logic r, bit b);
    stim_op_t op;
    op         = '{kind: OP_POINT, x: x, y: y, z: z, restart: r, idx: '0, data: '0, bursty: b};
    stim_q.push_back(op);
  endfunction

  function automatic void push_cfg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
    stim_op_t op;
    op = '{kind: OP_CFG, x: '0, y: '0, z: '0, restart: 1'b0, idx: idx, data: data, bursty: 1'b1};
    stim_q.push_back(op);
  endfunction

  // sender holds off until every box item is back, then settles
  function automatic void push_drain();
    stim_op_t op;
    op = '{kind: OP_DRAIN, x: '0, y: '0, z: '0, restart: 1'b0, idx: '0, data: '0, bursty: 1'b1};
    stim_q.push_back(op);
  endfunction

  function automatic logic [CW-1:0] pick_extreme();
    case ($urandom_range(0, 3))
      0:       return 20'h80000;
      1:       return 20'h7FFFF;
      2:       return 20'h00000;
      default: return 20'hFFFFF;
    endcase
  endfunction

  function automatic logic [CW-1:0] rand_coord();
    int s;
    case ($urandom_range(0, 5))
      0:       return pick_extreme();
      1, 2:    return CW'($urandom());
      default: begin
        s = int'($urandom_range(0, 8192)) - 4096;
        return CW'(s);
      end
    endcase
  endfunction

  function automatic logic [BW-1:0] rand_comp();
    int s;
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'h4000;
      2:       return 16'hC000;
      3:       return 16'h7FFF;
      4:       return 16'h8000;
      5:       begin
        s = int'($urandom_range(0, 4096)) - 2048;
        return BW'(s);
      end
      default: return BW'($urandom());
    endcase
  endfunction

  function automatic logic [AW-1:0] unit_axis(int lane, bit neg);
    logic [AW-1:0] w;
    w                 = '0;
    w[BW*lane +: BW]  = neg ? 16'hC000 : 16'h4000;
    return w;
  endfunction

  // assembly word for the start half extents of a random phase
  logic [DW-1:0] half_word = '0;

  function automatic void start_word_lane(int lane, logic [CW-1:0] v);
    half_word[CW*lane +: CW] = v;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: inputs move on the falling edge only
  // ---------------------------------------------------------------------------
  logic point_taken = 1'b0;
  logic cfg_taken   = 1'b0;
  logic box_taken   = 1'b0;
  logic bursty_now  = 1'b1;
  logic stim_done   = 1'b0;
  int   gap_left    = 0;
  int   settle      = 0;
  bit   draining    = 1'b0;

  always @(negedge clk_i) begin
    logic     nv_pt, nv_cf;
    stim_op_t op;
    if (rst_ni) begin
      nv_pt = pt_valid && !point_taken;
      nv_cf = cf_valid && !cfg_taken;
      if (!nv_pt && !nv_cf) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (draining) begin
          // wait for the last box item, then give the block time to go quiet
          if (box_expect_q.size() != 0) settle = 0;
          else if (settle < SETTLE_CYCLES) settle++;
          else draining = 1'b0;
        end else if (stim_q.size() != 0) begin
          op = stim_q.pop_front();
          bursty_now <= op.bursty;
          case (op.kind)
            OP_POINT: begin
              pt_x       <= op.x;
              pt_y       <= op.y;
              pt_z       <= op.z;
              pt_restart <= op.restart;
              nv_pt      = 1'b1;
              if (op.bursty && $urandom_range(0, 7) == 0) gap_left = $urandom_range(1, 14);
            end
            OP_CFG: begin
              cf_idx  <= op.idx;
              cf_data <= op.data;
              nv_cf   = 1'b1;
            end
            default: begin
              draining = 1'b1;
              settle   = 0;
            end
          endcase
        end
      end
      pt_valid  <= nv_pt;
      cf_valid  <= nv_cf;
      stim_done <= (stim_q.size() == 0) && !nv_pt && !nv_cf && !draining && (gap_left == 0);
    end
  end

  // Result side back-pressure: random stall bursts while bursty
  int hold_left = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0 && bursty_now) begin
        hold_left--;
        res_ready <= 1'b0;
      end else if (bursty_now && $urandom_range(0, 9) == 0) begin
        hold_left = $urandom_range(0, 13);
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample handshakes on the rising edge, check then predict
  // ---------------------------------------------------------------------------
  int err_count = 0;

  task automatic check_field(string name, longint want_v, longint got_v);
    if (want_v != got_v) begin
      $error("%s: expected %0d, got %0d", name, want_v, got_v);
      err_count++;
    end
  endtask

  always @(posedge clk_i) begin
    box_t want;
    point_taken = rst_ni && point_if.valid && point_if.ready;
    cfg_taken   = rst_ni && cfg_if.valid && cfg_if.ready;
    box_taken   = rst_ni && box_if.valid && box_if.ready;
    if (box_taken) begin
      if (box_expect_q.size() == 0) begin
        $error("box item with none expected: centre %0d %0d %0d", box_if.center_x,
               box_if.center_y, box_if.center_z);
        err_count++;
      end else begin
        want = box_expect_q.pop_front();
        check_field("center_x", want.center_x, box_if.center_x);
        check_field("center_y", want.center_y, box_if.center_y);
        check_field("center_z", want.center_z, box_if.center_z);
        check_field("half_i",   want.half_i,   box_if.half_i);
        check_field("half_j",   want.half_j,   box_if.half_j);
        check_field("half_k",   want.half_k,   box_if.half_k);
      end
    end
    if (cfg_taken) store_reg_write(cfg_if.index, cfg_if.data);
    if (point_taken)
      box_expect_q.push_back(grow_box_to_point(point_if.point_x, point_if.point_y,
                                               point_if.point_z, point_if.restart));
  end

  // Watchdog: too long without any handshake ends the run
  int quiet_cycles = 0;

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (point_taken || cfg_taken || box_taken) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("oriented_box_grow_to_point_test NOT OK");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int            n_rand, plen, spread, lane0, lane1;
    int            lanes [3];
    bit            last, bursty, tame, wide;
    logic [CW-1:0] bx, by, bz;
    logic [CW-1:0] vx, vy, vz;

    // Directed, reset register values (reset axes, start box at zero)
    push_point(20'h00000, 20'h00000, 20'h00000, 1'b0, 1'b1);
    push_point(20'h00001, 20'h00000, 20'h00000, 1'b1, 1'b1);  // excess of one: no change
    push_point(20'h00002, 20'h00000, 20'h00000, 1'b0, 1'b1);
    push_point(20'h7FFFF, 20'h80000, 20'h00000, 1'b0, 1'b1);
    push_point(20'h80000, 20'h7FFFF, 20'h7FFFF, 1'b0, 1'b1);
    push_point(20'h00000, 20'h00000, 20'h80000, 1'b0, 1'b1);
    push_point(20'h00003, 20'hFFFFD, 20'h00005, 1'b1, 1'b1);

    // Extreme, skewed, non-unit axes; start values out of range; junk in upper bits
    push_drain();
    push_cfg(REG_AXIS_I, {12'hFFF, 16'h0000, 16'h7FFF, 16'h7FFF});
    push_cfg(REG_AXIS_J, {12'hFFF, 16'h4000, 16'h0000, 16'h8000});
    push_cfg(REG_AXIS_K, {12'hFFF, 16'h8000, 16'h8000, 16'h0000});
    push_cfg(REG_START_CENTER, {20'h00000, 20'h7FFFF, 20'h80000});
    push_cfg(REG_START_HALF, {20'h80000, 20'h7FFFF, 20'hFFFFF});
    push_cfg(REG_UNUSED_A, '1);
    push_cfg(REG_UNUSED_B, '1);
    push_cfg(REG_UNUSED_C, '1);
    push_point(20'h7FFFF, 20'h7FFFF, 20'h7FFFF, 1'b1, 1'b1);
    push_point(20'h80000, 20'h80000, 20'h80000, 1'b0, 1'b1);
    push_point(20'h00000, 20'h00000, 20'h00000, 1'b1, 1'b1);
    push_point(20'h80000, 20'h7FFFF, 20'h80000, 1'b0, 1'b1);

    // Identity axes, centre at the bottom edge: half extent runs into its ceiling
    push_drain();
    push_cfg(REG_AXIS_I, DW'(unit_axis(0, 1'b0)));
    push_cfg(REG_AXIS_J, DW'(unit_axis(1, 1'b0)));
    push_cfg(REG_AXIS_K, DW'(unit_axis(2, 1'b0)));
    push_cfg(REG_START_CENTER, {20'h00000, 20'h00000, 20'h80000});
    push_cfg(REG_START_HALF, {20'hFFFFF, 20'h00000, 20'h7FFFF});
    push_point(20'h7FFFF, 20'h00000, 20'h00000, 1'b1, 1'b1);
    push_point(20'h7FFFF, 20'h7FFFF, 20'h80000, 1'b0, 1'b1);

    // Degenerate axes and all-ones start registers
    push_drain();
    push_cfg(REG_AXIS_I, '0);
    push_cfg(REG_AXIS_J, '0);
    push_cfg(REG_AXIS_K, '1);
    push_cfg(REG_START_CENTER, '1);
    push_cfg(REG_START_HALF, '1);
    push_point(20'h7FFFF, 20'h80000, 20'h7FFFF, 1'b1, 1'b1);
    push_point(20'h00000, 20'h00000, 20'h00000, 1'b0, 1'b1);

    // Random phases: new registers, then a run of points mostly clustered
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      last = (n_rand >= RAND_ITEMS - CALM_ITEMS);
      push_drain();
      tame  = ($urandom_range(0, 1) == 0);
      lane0 = $urandom_range(0, 2);
      lane1 = (lane0 + 1 + $urandom_range(0, 1)) % 3;
      lanes = '{lane0, lane1, 3 - lane0 - lane1};
      for (int a = 0; a < 3; a++) begin
        if ($urandom_range(0, 3) != 0) begin
          if (tame)
            push_cfg(AXIS_REG[a], {12'($urandom()),
                                   unit_axis(lanes[a], 1'($urandom_range(0, 1)))});
          else
            push_cfg(AXIS_REG[a], {12'($urandom()), rand_comp(), rand_comp(), rand_comp()});
        end
      end
      if ($urandom_range(0, 3) != 0)
        push_cfg(REG_START_CENTER, {rand_coord(), rand_coord(), rand_coord()});
      if ($urandom_range(0, 3) != 0) begin
        for (int n = 0; n < 3; n++) begin
          case ($urandom_range(0, 2))
            0:       vx = CW'($urandom_range(0, 20000));
            1:       vx = CW'($urandom());
            default: vx = pick_extreme();
          endcase
          start_word_lane(n, vx);
        end
        push_cfg(REG_START_HALF, half_word);
      end
      if ($urandom_range(0, 5) == 0)
        push_cfg(REG_UNUSED_A + CFG_IDX_W'($urandom_range(0, 2)), DW'({$urandom(), $urandom()}));

      if (last) plen = RAND_ITEMS - n_rand;
      else begin
        plen = $urandom_range(20, 120);
        if (n_rand + plen > RAND_ITEMS - CALM_ITEMS) plen = RAND_ITEMS - CALM_ITEMS - n_rand;
      end
      bursty = !last && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       spread = 64;
        1:       spread = 4096;
        2:       spread = 131072;
        default: spread = 0;  // full range
      endcase
      bx = rand_coord();
      by = rand_coord();
      bz = rand_coord();
      for (int k = 0; k < plen; k++) begin
        wide = (spread == 0) || ($urandom_range(0, 7) == 0);
        if (wide) begin
          vx = CW'($urandom());
          vy = CW'($urandom());
          vz = CW'($urandom());
        end else begin
          vx = bx + CW'(int'($urandom_range(0, 2 * spread)) - spread);
          vy = by + CW'(int'($urandom_range(0, 2 * spread)) - spread);
          vz = bz + CW'(int'($urandom_range(0, 2 * spread)) - spread);
        end
        // a phase usually opens from the start box
        push_point(vx, vy, vz,
                   (k == 0) ? ($urandom_range(0, 7) != 0) : ($urandom_range(0, 19) == 0),
                   bursty);
      end
      n_rand += plen;
    end

    // Reset once, released on a falling edge
    rst_ni = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (!(stim_done && box_expect_q.size() == 0)) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (err_count == 0) begin
      $display("oriented_box_grow_to_point_test OK");
    end else begin
      $display("oriented_box_grow_to_point_test NOT OK");
    end
    $finish;
  end

endmodule
